/* design/rle_bitmap_page_blitter_defines.svh */
// Assertion macros shared by the checker.
// Both macros expect clk_i and rst_ni in the scope where they are used.
`ifndef RLE_BITMAP_PAGE_BLITTER_DEFINES_SVH
`define RLE_BITMAP_PAGE_BLITTER_DEFINES_SVH

// Consequent must hold in the same cycle.
`define RBPB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the following cycle.
`define RBPB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/rbpb_pkg.sv */
`timescale 1ns / 1ps
package rbpb_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    PH_LEAD  = 2'd0,
    PH_VALUE = 2'd1,
    PH_COUNT = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    REG_ORIGIN_X    = 2'd0,
    REG_ORIGIN_Y    = 2'd1,
    REG_WIDTH_PX    = 2'd2,
    REG_HEIGHT_ROWS = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'd0,
    ST_IDLE  = 3'd1,
    ST_EXEC  = 3'd2,
    ST_DRAW  = 3'd3,
    ST_RESP  = 3'd4
  } state_e;

  localparam logic [7:0] ESCAPE_CODE     = 8'h76;
  localparam logic [7:0] WIDTH_PX_RST    = 8'd128;
  localparam logic [6:0] HEIGHT_ROWS_RST = 7'd64;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef struct packed {
    logic [6:0] origin_x;
    logic [5:0] origin_y;
    logic [7:0] width_px;
    logic [6:0] height_rows;
  } cfg_t;

  typedef struct packed {
    logic take;
    logic exec;
    logic draw;
    logic clear;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic draw_start;
    logic draw_last;
    logic out_free;
  } dp_stat_t;

endpackage

/* design/rbpb_if.sv */
`timescale 1ns / 1ps
interface rbpb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] data_byte;
  logic [9:0] read_address;

  modport source (output valid, output opcode, output data_byte, output read_address,
                  input ready);
  modport sink (input valid, input opcode, input data_byte, input read_address,
                output ready);
endinterface

interface rbpb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       bitmap_done;
  logic [6:0] row_now;

  modport source (output valid, output read_data, output bitmap_done, output row_now,
                  input ready);
  modport sink (input valid, input read_data, input bitmap_done, input row_now,
                output ready);
endinterface

/* design/rbpb_regs.sv */
`timescale 1ns / 1ps
module rbpb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rbpb_pkg::PADDR_W-1:0]  paddr,
  input  logic [rbpb_pkg::PDATA_W-1:0]  pwdata,
  output logic [rbpb_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output rbpb_pkg::cfg_t                cfg_o
);
  import rbpb_pkg::*;

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_ORIGIN_X:    cfg_d.origin_x    = pwdata[6:0];
        REG_ORIGIN_Y:    cfg_d.origin_y    = pwdata[5:0];
        REG_WIDTH_PX:    cfg_d.width_px    = pwdata[7:0];
        REG_HEIGHT_ROWS: cfg_d.height_rows = pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ORIGIN_X:    prdata = PDATA_W'(cfg_q.origin_x);
      REG_ORIGIN_Y:    prdata = PDATA_W'(cfg_q.origin_y);
      REG_WIDTH_PX:    prdata = PDATA_W'(cfg_q.width_px);
      REG_HEIGHT_ROWS: prdata = PDATA_W'(cfg_q.height_rows);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x    <= '0;
      cfg_q.origin_y    <= '0;
      cfg_q.width_px    <= WIDTH_PX_RST;
      cfg_q.height_rows <= HEIGHT_ROWS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* design/rbpb_ctrl.sv */
`timescale 1ns / 1ps
module rbpb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rbpb_pkg::dp_stat_t stat_i,
  output rbpb_pkg::dp_cmd_t  cmd_o
);
  import rbpb_pkg::*;

  state_e state_q;
  state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = stat_i.draw_start ? ST_DRAW : ST_RESP;
      end
      ST_DRAW: begin
        cmd_o.draw = 1'b1;
        if (stat_i.draw_last) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

/* design/rbpb_dp.sv */
`timescale 1ns / 1ps
module rbpb_dp #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rbpb_pkg::cfg_t     cfg_i,
  input  rbpb_pkg::dp_cmd_t  cmd_i,
  output rbpb_pkg::dp_stat_t stat_o,
  input  logic [1:0]         opcode_i,
  input  logic [7:0]         data_byte_i,
  input  logic [9:0]         read_address_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         read_data_o,
  output logic               bitmap_done_o,
  output logic [6:0]         row_now_o
);
  import rbpb_pkg::*;

  localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = PAGE_COUNT * SCREEN_WIDTH;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam logic [AW-1:0] W_AW       = AW'(SCREEN_WIDTH);
  localparam logic [AW-1:0] CLEAR_LAST = AW'(STORE_BYTES - 1);
  localparam logic [12:0]   X_END      = 13'(SCREEN_WIDTH);
  localparam logic [12:0]   X_LAST     = 13'(SCREEN_WIDTH - 1);
  localparam logic [7:0]    RY_TOP     = 8'(SCREEN_HEIGHT - 1);

  // item
  opcode_e     op_q;
  logic [7:0]  byte_q;
  logic [9:0]  raddr_q;

  // decoder state
  phase_e      phase_q, phase_d;
  logic [7:0]  held_q, held_d;
  logic [6:0]  row_q, row_d;
  logic [11:0] pc_q, pc_d;

  // draw engine
  logic [12:0]   x_q;
  logic [10:0]   left_q;
  logic [7:0]    val_q;
  logic [AW-1:0] base_q;
  logic [2:0]    bit_q;
  logic          wr_pend_q;
  logic [AW-1:0] wr_addr_q;
  logic          wr_set_q;
  logic [AW-1:0] clr_q;

  // frame store
  logic [7:0]    mem [STORE_BYTES];
  logic [7:0]    mem_rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  // output register
  logic        out_valid_q;
  logic [7:0]  read_data_q;
  logic        done_out_q;
  logic [6:0]  row_out_q;

  logic          done;
  logic          rd_in_range;
  logic          exec_byte;
  logic          entry;
  logic [7:0]    ent_val;
  logic [7:0]    ent_rep;
  logic [10:0]   total;
  logic [11:0]   pc_sum;
  logic [7:0]    row_sum;
  logic [7:0]    ry_full;
  logic          row_ok;
  logic [12:0]   x_start;
  logic [AW-1:0] draw_addr;
  logic [7:0]    bit_mask;

  assign done        = row_q >= cfg_i.height_rows;
  assign rd_in_range = 32'(raddr_q) < STORE_BYTES;
  assign exec_byte   = cmd_i.exec && (op_q == OP_BYTE) && !done;

  assign total   = {ent_rep, 3'b000};
  assign pc_sum  = pc_q + {1'b0, total};
  assign row_sum = {2'b00, cfg_i.origin_y} + {1'b0, row_q};
  assign ry_full = RY_TOP - row_sum;
  assign row_ok  = row_sum <= RY_TOP;
  assign x_start = {6'd0, cfg_i.origin_x} + {1'b0, pc_q} + 13'd1;

  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    row_d   = row_q;
    pc_d    = pc_q;
    entry   = 1'b0;
    ent_val = byte_q;
    ent_rep = 8'd1;
    case (phase_q)
      PH_VALUE: begin
        phase_d = PH_COUNT;
        held_d  = byte_q;
      end
      PH_COUNT: begin
        phase_d = PH_LEAD;
        entry   = 1'b1;
        ent_val = held_q;
        ent_rep = byte_q;
      end
      default: begin
        if (byte_q == ESCAPE_CODE) begin
          phase_d = PH_VALUE;
        end else begin
          entry = 1'b1;
        end
      end
    endcase
    if (entry) begin
      if (pc_sum >= {4'd0, cfg_i.width_px}) begin
        row_d = row_q + 7'd1;
        pc_d  = '0;
      end else begin
        pc_d = pc_sum;
      end
    end
  end

  assign stat_o.draw_start = exec_byte && entry && row_ok && (ent_rep != 8'd0)
                             && (x_start < X_END);
  assign stat_o.draw_last  = (left_q == 11'd1) || (x_q >= X_LAST);
  assign stat_o.clear_last = clr_q == CLEAR_LAST;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD;
      held_q  <= '0;
      row_q   <= '0;
      pc_q    <= '0;
    end else if (cmd_i.exec && op_q == OP_START) begin
      phase_q <= PH_LEAD;
      held_q  <= '0;
      row_q   <= '0;
      pc_q    <= '0;
    end else if (exec_byte) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      row_q   <= row_d;
      pc_q    <= pc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      op_q    <= opcode_e'(opcode_i);
      byte_q  <= data_byte_i;
      raddr_q <= read_address_i;
    end
  end

  // Entry setup uses row and pixel count from before this entry.
  assign draw_addr = base_q + AW'(x_q);

  always_ff @(posedge clk_i) begin
    if (exec_byte && entry) begin
      x_q    <= x_start;
      left_q <= total;
      val_q  <= ent_val;
      base_q <= AW'(ry_full[7:3]) * W_AW;
      bit_q  <= ry_full[2:0];
    end else if (cmd_i.draw) begin
      x_q    <= x_q + 13'd1;
      left_q <= left_q - 11'd1;
      val_q  <= {val_q[6:0], val_q[7]};
    end
  end

  // Read in the draw cycle, write back in the cycle after.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pend_q <= 1'b0;
    end else begin
      wr_pend_q <= cmd_i.draw;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.draw) begin
      wr_addr_q <= draw_addr;
      wr_set_q  <= val_q[7];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  assign bit_mask = 8'd1 << bit_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_addr_q;
    mem_wdata = wr_set_q ? (mem_rdata_q | bit_mask) : (mem_rdata_q & ~bit_mask);
    if (cmd_i.clear) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (wr_pend_q) begin
      mem_we = 1'b1;
    end
  end

  assign mem_re    = cmd_i.draw || (cmd_i.exec && op_q == OP_READ && rd_in_range);
  assign mem_raddr = cmd_i.draw ? draw_addr : AW'(raddr_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      read_data_q <= (op_q == OP_READ && rd_in_range) ? mem_rdata_q : 8'd0;
      done_out_q  <= done;
      row_out_q   <= row_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = read_data_q;
  assign bitmap_done_o = done_out_q;
  assign row_now_o     = row_out_q;

endmodule

/* design/rle_bitmap_page_blitter.sv */
`timescale 1ns / 1ps
// Run-length coded 1-bit bitmap decoder that draws into an internal page-organized
// frame store (SCREEN_WIDTH bytes per page, one page per eight screen rows) and reads
// it back a byte at a time. Each input beat returns exactly one result beat. After
// reset the frame store is zeroed by a sweep of ((SCREEN_HEIGHT+7)/8)*SCREEN_WIDTH
// bytes (1024 at the defaults); input is not taken during it, register writes are.
// Items are processed one at a time: an accepted beat goes through the execute state,
// the draw state for its pixels and the response state before the next beat can be
// accepted; every pixel is a read-modify-write on the single-read, single-write frame
// store. A literal byte draws up to 8 pixels, a run up to 8 * count; drawing stops at
// the right store edge and rows outside the store draw nothing. A finished result
// waits in an output register and does not stall the next item until it completes.
module rle_bitmap_page_blitter #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rbpb_in_if.sink                       in_i,
  rbpb_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rbpb_pkg::PADDR_W-1:0]  paddr,
  input  logic [rbpb_pkg::PDATA_W-1:0]  pwdata,
  output logic [rbpb_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import rbpb_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  assign in_i.ready = in_ready;

  rbpb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rbpb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rbpb_dp #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .opcode_i       (in_i.opcode),
    .data_byte_i    (in_i.data_byte),
    .read_address_i (in_i.read_address),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .read_data_o    (out_o.read_data),
    .bitmap_done_o  (out_o.bitmap_done),
    .row_now_o      (out_o.row_now)
  );

endmodule

/* design/rbpb_checker.sv */
`timescale 1ns / 1ps
`include "rle_bitmap_page_blitter_defines.svh"
module rbpb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [7:0]                    read_data,
  input logic                          bitmap_done,
  input logic [6:0]                    row_now,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [rbpb_pkg::PADDR_W-1:0]  paddr,
  input logic [rbpb_pkg::PDATA_W-1:0]  pwdata,
  input logic                          pready
);
  import rbpb_pkg::*;

  logic [6:0]  height_q;
  logic [1:0]  owed_q;
  logic [1:0]  owed_d;
  logic [15:0] out_bits;
  logic        in_beat;
  logic        out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;
  assign out_bits = {read_data, bitmap_done, row_now};
  assign owed_d   = owed_q + {1'b0, in_beat} - {1'b0, out_beat};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= HEIGHT_ROWS_RST;
      owed_q   <= '0;
    end else begin
      owed_q <= owed_d;
      if (psel && penable && pwrite && pready
          && reg_idx_e'(paddr[3:2]) == REG_HEIGHT_ROWS) begin
        height_q <= pwdata[6:0];
      end
    end
  end

  `RBPB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")
  `RBPB_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_bits), "result changed")
  `RBPB_ASSERT_SAME(a_no_extra, out_valid, owed_q != 2'd0, "result beat without input beat")
  `RBPB_ASSERT_SAME(a_done_flag, out_valid, bitmap_done == (row_now >= height_q), "bad done")

endmodule

bind rle_bitmap_page_blitter rbpb_checker u_rbpb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_i.valid),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .read_data   (out_o.read_data),
  .bitmap_done (out_o.bitmap_done),
  .row_now     (out_o.row_now),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .pready      (pready)
);

/* tb/rle_bitmap_page_blitter_tb.sv */
`timescale 1ns / 1ps
module rle_bitmap_page_blitter_tb;
  import rbpb_pkg::*;

  localparam int SCR_W       = 128;
  localparam int SCR_H       = 64;
  localparam int STORE_BYTES = ((SCR_H + 7) / 8) * SCR_W;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [7:0] read_data;
    logic       bitmap_done;
    logic [6:0] row_now;
  } blit_result_t;

  // Decoder state, frame contents and the queue of results still owed by the block.
  class blit_model;
    logic [7:0]   frame [STORE_BYTES];
    phase_e       phase;
    logic [7:0]   held;
    logic [6:0]   row;
    logic [11:0]  pix;
    logic [6:0]   org_x;
    logic [5:0]   org_y;
    logic [7:0]   wid;
    logic [6:0]   hgt;
    blit_result_t result_fifo[$];
    int           errors;
    int           checked;

    function new();
      foreach (frame[i]) frame[i] = '0;
      phase   = PH_LEAD;
      held    = '0;
      row     = '0;
      pix     = '0;
      org_x   = '0;
      org_y   = '0;
      wid     = WIDTH_PX_RST;
      hgt     = HEIGHT_ROWS_RST;
      errors  = 0;
      checked = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [31:0] v);
      case (idx)
        REG_ORIGIN_X: org_x = v[6:0];
        REG_ORIGIN_Y: org_y = v[5:0];
        REG_WIDTH_PX: wid   = v[7:0];
        default:      hgt   = v[6:0];
      endcase
    endfunction

    function bit done();
      return row >= hgt;
    endfunction

    // Rows are flipped; pixels beyond the right edge or off the screen are dropped.
    function void draw(logic [7:0] value, logic [7:0] rep);
      int ry;
      int x;
      int total;
      int addr;
      ry    = SCR_H - 1 - (int'(org_y) + int'(row));
      total = int'(rep) * 8;
      if (ry >= 0 && ry < SCR_H) begin
        for (int k = 0; k < total; k++) begin
          x = int'(org_x) + int'(pix) + k + 1;
          if (x < SCR_W) begin
            addr = (ry / 8) * SCR_W + x;
            frame[addr][ry % 8] = value[7 - (k % 8)];
          end
        end
      end
      pix = pix + 12'(total);
      if (pix >= wid) begin
        row = row + 7'd1;
        pix = '0;
      end
    endfunction

    function void apply_beat(opcode_e op, logic [7:0] d, logic [9:0] a);
      blit_result_t r;
      r = '0;
      case (op)
        OP_START: begin
          phase = PH_LEAD;
          held  = '0;
          row   = '0;
          pix   = '0;
        end
        OP_BYTE: begin
          if (!done()) begin
            case (phase)
              PH_VALUE: begin
                held  = d;
                phase = PH_COUNT;
              end
              PH_COUNT: begin
                phase = PH_LEAD;
                draw(held, d);
              end
              default: begin
                if (d == ESCAPE_CODE) phase = PH_VALUE;
                else draw(d, 8'd1);
              end
            endcase
          end
        end
        OP_READ: r.read_data = frame[a];
        default: ;
      endcase
      r.bitmap_done = done();
      r.row_now     = row;
      result_fifo.push_back(r);
    endfunction

    function void check_result(logic [7:0] rd, logic dn, logic [6:0] rn);
      blit_result_t want;
      if (result_fifo.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result beat with nothing pending: read_data %h done %b row %0d",
                   $time, rd, dn, rn);
        return;
      end
      want = result_fifo.pop_front();
      checked++;
      if (rd !== want.read_data || dn !== want.bitmap_done || rn !== want.row_now) begin
        errors++;
        if (errors <= 10)
          $display("%0t: beat %0d mismatch exp/act: read_data %h/%h done %b/%b row %0d/%0d",
                   $time, checked, want.read_data, rd, want.bitmap_done, dn,
                   want.row_now, rn);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic        pready;

  rbpb_in_if  in_if ();
  rbpb_out_if out_if ();

  rle_bitmap_page_blitter #(
    .SCREEN_WIDTH (SCR_W),
    .SCREEN_HEIGHT(SCR_H)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  blit_model frame_pred = new();

  int stall_cycles = 0;
  int burst_left   = 0;
  int n_sent       = 0;
  int n_bytes      = 0;
  int n_reads      = 0;
  int n_settings   = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready)
        frame_pred.apply_beat(opcode_e'(in_if.opcode), in_if.data_byte, in_if.read_address);
      if (out_if.valid && out_if.ready)
        frame_pred.check_result(out_if.read_data, out_if.bitmap_done, out_if.row_now);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (psel && penable))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
    $display("** rle_bitmap_page_blitter: FAILED **");
    $finish;
  end

  // Receiver stalls: the mode is re-picked at random from four, always-ready among them.
  initial begin
    int rx_mode;
    int rx_left;
    int rx_tick;
    rx_mode = 0;
    rx_left = 0;
    rx_tick = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(16, 160);
      end else begin
        rx_left--;
      end
      rx_tick++;
      case (rx_mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= 1'($urandom_range(0, 1));
        2:       out_if.ready <= ($urandom_range(0, 3) == 0);
        default: out_if.ready <= (rx_tick % 5 != 0);
      endcase
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    frame_pred.set_reg(idx, v);
    @(posedge clk_i);
  endtask

  task automatic program_regs(logic [6:0] ox, logic [5:0] oy, logic [7:0] w, logic [6:0] h);
    write_reg(REG_ORIGIN_X, 32'(ox));
    write_reg(REG_ORIGIN_Y, 32'(oy));
    write_reg(REG_WIDTH_PX, 32'(w));
    write_reg(REG_HEIGHT_ROWS, 32'(h));
    n_settings++;
  endtask

  // One beat; valid stays high within a burst, drops for a random gap after it.
  task automatic send(opcode_e op, logic [7:0] d, logic [9:0] a);
    in_if.valid        <= 1'b1;
    in_if.opcode       <= op;
    in_if.data_byte    <= d;
    in_if.read_address <= a;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    n_sent++;
    if (op == OP_BYTE) n_bytes++;
    if (op == OP_READ) n_reads++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 12);
    end
  endtask

  task automatic send_byte(logic [7:0] d);
    send(OP_BYTE, d, 10'($urandom_range(0, 1023)));
  endtask

  task automatic send_read(logic [9:0] a);
    send(OP_READ, 8'($urandom_range(0, 255)), a);
  endtask

  task automatic send_op(opcode_e op);
    send(op, 8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)));
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (frame_pred.result_fifo.size() != 0) @(posedge clk_i);
  endtask

  // Half uniform, half near the drawing origin where pixels actually land.
  function automatic logic [9:0] pick_addr();
    int pg;
    int col;
    if ($urandom_range(0, 1)) return 10'($urandom_range(0, STORE_BYTES - 1));
    pg  = $urandom_range(0, (SCR_H / 8) - 1);
    col = (int'(frame_pred.org_x) + $urandom_range(1, 64)) % SCR_W;
    return 10'(pg * SCR_W + col);
  endfunction

  task automatic run_phase(int quota);
    int n;
    int r;
    int c;
    logic [7:0] cnt;
    n = 0;
    if ($urandom_range(0, 3) != 0) send_op(OP_START);
    while (n < quota) begin
      r = $urandom_range(0, 99);
      if (frame_pred.done()) begin
        if (r < 70) begin
          send_op(OP_START);
          n++;
        end else if (r < 85) begin
          send_read(pick_addr());
          n++;
        end else begin
          send_byte(8'($urandom_range(0, 255)));
        end
      end else if (r < 55) begin
        send_byte(8'($urandom_range(0, 255)));
        n++;
      end else if (r < 75) begin
        c   = $urandom_range(0, 99);
        cnt = (c < 80) ? 8'($urandom_range(0, 3)) :
              (c < 95) ? 8'($urandom_range(4, 20)) : 8'($urandom_range(21, 255));
        send_byte(ESCAPE_CODE);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(cnt);
        n += 3;
      end else if (r < 93) begin
        send_read(pick_addr());
        n++;
      end else if (r < 96) begin
        send_op(OP_NONE);
        n++;
      end else if (r < 98) begin
        send_op(OP_START);
        n++;
      end else begin
        // run cut short by a restart
        send_byte(ESCAPE_CODE);
        if (r == 99) send_byte(8'($urandom_range(0, 255)));
        send_op(OP_START);
        n += 2;
      end
    end
    settle();
  endtask

  initial begin
    rst_ni             <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.opcode       <= OP_NONE;
    in_if.data_byte    <= '0;
    in_if.read_address <= '0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, zero repeat, long run, bytes after done, unused opcode
    program_regs(7'd0, 6'd0, 8'd16, 7'd2);
    send_op(OP_START);
    send_read(10'd0);
    send_read(10'd1023);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(ESCAPE_CODE);
    send_byte(8'hA5);
    send_byte(8'h00);
    send_byte(ESCAPE_CODE);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_op(OP_NONE);
    send_read(10'(7 * SCR_W + 1));
    send_read(10'(7 * SCR_W + 16));
    send_read(10'(7 * SCR_W + 127));
    settle();
    // zero height: done at once; then a mid-bitmap change of height with zero width, right edge
    program_regs(7'd127, 6'd63, 8'd0, 7'd0);
    send_op(OP_START);
    send_byte(8'h12);
    settle();
    program_regs(7'd127, 6'd63, 8'd0, 7'd127);
    send_byte(8'hF0);
    send_byte(ESCAPE_CODE);
    send_byte(8'h3C);
    send_byte(8'h01);
    send_read(10'd0);
    settle();

    program_regs(7'd0, 6'd0, WIDTH_PX_RST, HEIGHT_ROWS_RST);
    run_phase(150);
    program_regs(7'd127, 6'd63, 8'd255, 7'd127);
    run_phase(150);
    program_regs(7'($urandom_range(0, 127)), 6'($urandom_range(0, 63)), 8'd1, 7'd1);
    run_phase(150);
    program_regs(7'($urandom_range(0, 127)), 6'($urandom_range(0, 63)), 8'd0,
                 7'($urandom_range(1, 8)));
    run_phase(150);
    repeat (4) begin
      program_regs(7'($urandom_range(0, 127)), 6'($urandom_range(0, 63)),
                   8'($urandom_range(1, 48)), 7'($urandom_range(1, 12)));
      run_phase(150);
    end

    repeat (200) @(posedge clk_i);
    if (frame_pred.result_fifo.size() != 0) begin
      $display("%0d result beats never arrived", frame_pred.result_fifo.size());
      frame_pred.errors += frame_pred.result_fifo.size();
    end

    $display("Sent %0d beats (%0d coded bytes, %0d frame reads) under %0d register settings.",
             n_sent, n_bytes, n_reads, n_settings);
    $display("Checked %0d result beats, %0d errors.", frame_pred.checked, frame_pred.errors);
    if (frame_pred.errors == 0) begin
      $display("** rle_bitmap_page_blitter: PASSED **");
    end else begin
      $display("** rle_bitmap_page_blitter: FAILED **");
    end
    $finish;
  end

endmodule
